FILE: rtl/core/swrq_pkg.sv
// ----------------------------------------------------------------------------
// swrq_pkg
// Shared constants, register map, state encoding and divider port structs for
// the sliding window reception quality block.
// ----------------------------------------------------------------------------
package swrq_pkg;

    localparam int unsigned RING_DEPTH_DEFAULT = 256;

    localparam int unsigned WIN_W   = 17;
    localparam int unsigned EXP_W   = 16;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned QUAL_W  = 15;

    localparam logic [TIME_W-1:0] HOLDOFF_SECONDS = 32'd30;
    localparam logic [QUAL_W-1:0] QUALITY_MAX     = 15'd32767;
    localparam logic [6:0]        PERCENT_SCALE   = 7'd100;

    localparam logic [WIN_W-1:0]  WINDOW_RESET   = 17'd3600;
    localparam logic [EXP_W-1:0]  EXPECTED_RESET = 16'd60;
    localparam logic [TIME_W-1:0] START_RESET    = 32'd0;

    localparam int unsigned DIV_W     = 48;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_W);

    typedef enum logic [1:0] {
        REG_WINDOW   = 2'd0,
        REG_EXPECTED = 2'd1,
        REG_START    = 2'd2
    } reg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_STORE,
        ST_PRUNE_RD,
        ST_PRUNE,
        ST_MUL,
        ST_EXP_START,
        ST_EXP_WAIT,
        ST_QUAL_START,
        ST_QUAL_WAIT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] numerator;
        logic [DIV_W-1:0] denominator;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

endpackage

FILE: rtl/core/swrq_stamp_ram.sv
// ----------------------------------------------------------------------------
// swrq_stamp_ram
// Timestamp ring storage: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module swrq_stamp_ram #(
    parameter int unsigned DEPTH  = 256,
    parameter int unsigned ADDR_W = 8,
    parameter int unsigned DATA_W = 32
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/swrq_div.sv
// ----------------------------------------------------------------------------
// swrq_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module swrq_div
    import swrq_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [DIV_W-1:0]     rem_reg, rem_next;
    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [DIV_W-1:0]     den_reg, den_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_W:0]       trial;
    logic [DIV_W:0]       diff;

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[DIV_W-1]};
        diff      = trial - {1'b0, den_reg};
        if (req.start) begin
            rem_next  = '0;
            quo_next  = req.numerator;
            den_next  = req.denominator;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, den_reg}) begin
                rem_next = diff[DIV_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end else begin
                rem_next = trial[DIV_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

FILE: rtl/core/sliding_window_reception_quality.sv
// ----------------------------------------------------------------------------
// sliding_window_reception_quality
// Reception quality over a sliding time window, stamps held in a ring memory.
// ----------------------------------------------------------------------------
// One word in, one word out. A word before start_time or less than 30 s after
// it skips the ring and goes straight to the emit state. Any other word is
// stored, then the ring is pruned (up to 255 stamps with the default depth),
// then the expected count and the percentage are worked out. The next word
// can be taken once the result has gone to the output register. The ring
// memory has a single read port and prunes one stamp per cycle. Each of the
// two divisions (expected count, then percentage) runs on the bit-serial
// divider. The ring needs no clearing after reset; only live entries are ever
// read. Input is taken only when the block is idle. A finished result waits
// in the output register. While that register still holds an untaken word,
// the block holds its next result back; it may still take one more input.
module sliding_window_reception_quality
    import swrq_pkg::*;
#(
    parameter int unsigned RING_DEPTH = RING_DEPTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] arrival_time
    // result words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [14:0] quality_percent, [15] zero
    output logic [1:0]  m_tuser    // [0] in_holdoff, [1] ring_overflow
);

    localparam int unsigned AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int unsigned CW = $clog2(RING_DEPTH + 1);

    state_t state_reg, state_next;

    logic [WIN_W-1:0]  win_reg;
    logic [EXP_W-1:0]  exp_cnt_reg;
    logic [TIME_W-1:0] start_reg;

    logic [TIME_W-1:0] now_reg, now_next;
    logic [TIME_W-1:0] cutoff_reg, cutoff_next;
    logic [AW-1:0]     head_reg, head_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              ovf_reg, ovf_next;
    logic              holdoff_reg, holdoff_next;
    logic [QUAL_W-1:0] quality_reg, quality_next;
    logic [DIV_W-1:0]  prod_reg, prod_next;
    logic [EXP_W-1:0]  expected_reg, expected_next;

    logic              m_valid_reg, m_valid_next;
    logic [QUAL_W-1:0] m_quality_reg, m_quality_next;
    logic              m_holdoff_reg, m_holdoff_next;
    logic              m_ovf_reg, m_ovf_next;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [AW-1:0]     ram_raddr;
    logic [TIME_W-1:0] ram_rdata;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic              cfg_wr;
    logic [WIN_W-1:0]  win_eff;
    logic [TIME_W-1:0] win32;
    logic [TIME_W-1:0] since_start;
    logic [TIME_W-1:0] now_minus_win;
    logic              holdoff_calc;
    logic [TIME_W-1:0] cutoff_calc;
    logic              full;
    logic [AW-1:0]     head_inc;
    logic [AW-1:0]     head_eff;
    logic [CW-1:0]     count_eff;
    logic [CW:0]       wsum;
    logic [CW:0]       wsum_wrap;

    // ---------------- configuration ----------------
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg     <= WINDOW_RESET;
            exp_cnt_reg <= EXPECTED_RESET;
            start_reg   <= START_RESET;
        end else if (cfg_wr) begin
            case (reg_index_t'(paddr[3:2]))
                REG_WINDOW:   win_reg     <= pwdata[WIN_W-1:0];
                REG_EXPECTED: exp_cnt_reg <= pwdata[EXP_W-1:0];
                REG_START:    start_reg   <= pwdata;
                default:      ;
            endcase
        end
    end

    always_comb begin
        case (reg_index_t'(paddr[3:2]))
            REG_WINDOW:   prdata = {15'd0, win_reg};
            REG_EXPECTED: prdata = {16'd0, exp_cnt_reg};
            REG_START:    prdata = start_reg;
            default:      prdata = '0;
        endcase
    end

    // ---------------- arrival checks ----------------
    assign win_eff       = (win_reg == '0) ? WIN_W'(1) : win_reg;
    assign win32         = {15'd0, win_eff};
    assign since_start   = s_tdata - start_reg;
    assign now_minus_win = s_tdata - win32;
    assign holdoff_calc  = (s_tdata < start_reg) || (since_start < HOLDOFF_SECONDS);
    assign cutoff_calc   = ((s_tdata >= win32) && (now_minus_win > start_reg))
                           ? now_minus_win : start_reg;

    // ---------------- ring indexing ----------------
    assign full      = (count_reg == CW'(RING_DEPTH));
    assign head_inc  = (head_reg == AW'(RING_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign head_eff  = full ? head_inc : head_reg;
    assign count_eff = full ? CW'(RING_DEPTH - 1) : count_reg;
    assign wsum      = (CW+1)'(head_eff) + (CW+1)'(count_eff);
    assign wsum_wrap = (wsum >= (CW+1)'(RING_DEPTH)) ? wsum - (CW+1)'(RING_DEPTH) : wsum;
    assign ram_waddr = wsum_wrap[AW-1:0];
    assign ram_raddr = (state_reg == ST_PRUNE) ? head_inc : head_reg;

    // ---------------- control ----------------
    always_comb begin
        state_next     = state_reg;
        now_next       = now_reg;
        cutoff_next    = cutoff_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        holdoff_next   = holdoff_reg;
        quality_next   = quality_reg;
        prod_next      = prod_reg;
        expected_next  = expected_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_quality_next = m_quality_reg;
        m_holdoff_next = m_holdoff_reg;
        m_ovf_next     = m_ovf_reg;
        ram_we         = 1'b0;
        s_tready       = 1'b0;
        div_req        = '0;

        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    now_next    = s_tdata;
                    cutoff_next = cutoff_calc;
                    if (holdoff_calc) begin
                        holdoff_next = 1'b1;
                        ovf_next     = 1'b0;
                        quality_next = '0;
                        state_next   = ST_EMIT;
                    end else begin
                        holdoff_next = 1'b0;
                        state_next   = ST_STORE;
                    end
                end
            end
            ST_STORE: begin
                ram_we     = 1'b1;
                ovf_next   = full;
                head_next  = head_eff;
                count_next = count_eff + 1'b1;
                state_next = ST_PRUNE_RD;
            end
            ST_PRUNE_RD: begin
                state_next = ST_PRUNE;
            end
            ST_PRUNE: begin
                if ((count_reg != '0) && (ram_rdata < cutoff_reg)) begin
                    head_next  = head_inc;
                    count_next = count_reg - 1'b1;
                end else begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                prod_next  = DIV_W'(exp_cnt_reg) * DIV_W'(now_reg - cutoff_reg);
                state_next = ST_EXP_START;
            end
            ST_EXP_START: begin
                div_req.start       = 1'b1;
                div_req.numerator   = prod_reg;
                div_req.denominator = DIV_W'(win_eff);
                state_next          = ST_EXP_WAIT;
            end
            ST_EXP_WAIT: begin
                if (div_rsp.done) begin
                    expected_next = (div_rsp.quotient == '0) ? EXP_W'(1)
                                                              : div_rsp.quotient[EXP_W-1:0];
                    state_next    = ST_QUAL_START;
                end
            end
            ST_QUAL_START: begin
                div_req.start       = 1'b1;
                div_req.numerator   = DIV_W'(count_reg) * DIV_W'(PERCENT_SCALE);
                div_req.denominator = DIV_W'(expected_reg);
                state_next          = ST_QUAL_WAIT;
            end
            ST_QUAL_WAIT: begin
                if (div_rsp.done) begin
                    quality_next = (div_rsp.quotient > DIV_W'(QUALITY_MAX))
                                   ? QUALITY_MAX : div_rsp.quotient[QUAL_W-1:0];
                    state_next   = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next   = 1'b1;
                    m_quality_next = quality_reg;
                    m_holdoff_next = holdoff_reg;
                    m_ovf_next     = ovf_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        now_reg       <= now_next;
        cutoff_reg    <= cutoff_next;
        ovf_reg       <= ovf_next;
        holdoff_reg   <= holdoff_next;
        quality_reg   <= quality_next;
        prod_reg      <= prod_next;
        expected_reg  <= expected_next;
        m_quality_reg <= m_quality_next;
        m_holdoff_reg <= m_holdoff_next;
        m_ovf_reg     <= m_ovf_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_quality_reg};
    assign m_tuser  = {m_ovf_reg, m_holdoff_reg};

    // ---------------- submodules ----------------
    swrq_stamp_ram #(
        .DEPTH  (RING_DEPTH),
        .ADDR_W (AW),
        .DATA_W (TIME_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (now_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    swrq_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(RING_DEPTH))
        else $error("stamp count beyond ring depth");

    a_store_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_STORE) |=> (count_reg != '0))
        else $error("ring empty after store");

    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("holdoff word flagged as overflow");

    a_holdoff_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
        else $error("holdoff word with non-zero quality");

    a_div_done_waiting: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> ((state_reg == ST_EXP_WAIT) || (state_reg == ST_QUAL_WAIT)))
        else $error("divider finished outside a wait state");
`endif

endmodule

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for sliding_window_reception_quality. Arrival times are
// streamed in over the slave side and every result word is checked field by
// field against a behavioural copy of the stamp ring, pruning and divisions
// kept in step with the APB register writes. Directed words cover the holdoff
// band, zero window and zero expected count, out-of-order times and the ends
// of the time range; random phases cover ring overflow, heavy pruning and
// back-pressure with random gaps on both sides.
// ----------------------------------------------------------------------------
module testbench;
    import swrq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned DEPTH = RING_DEPTH_DEFAULT;
    localparam int unsigned SLOT_W = $clog2(DEPTH);
    localparam logic [1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic [TIME_W-1:0] arrival;
        logic [QUAL_W-1:0] quality;
        logic              holdoff;
        logic              overflow;
    } score_t;

    logic        aclk;
    logic        aresetn;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // [31:0] arrival_time
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // [14:0] quality_percent, [15] zero
    logic [1:0]  m_tuser;   // [0] in_holdoff, [1] ring_overflow

    // register copies
    logic [WIN_W-1:0]  cfg_window;
    logic [EXP_W-1:0]  cfg_expected;
    logic [TIME_W-1:0] cfg_start;

    // stamp ring copy
    logic [TIME_W-1:0] stamp_copy [DEPTH];
    logic [SLOT_W-1:0] oldest_slot;
    int unsigned       live_stamps;

    score_t      pending_scores [$];
    int unsigned mismatches;
    int unsigned wall_clock;
    int unsigned long_hold;
    bit          steady;

    sliding_window_reception_quality uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic flag_mismatch(input string msg);
        $display("%0t mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    function automatic score_t score_arrival(input logic [TIME_W-1:0] now);
        score_t            r;
        logic [TIME_W-1:0] win;
        logic [TIME_W-1:0] cutoff;
        logic [TIME_W-1:0] span;
        logic [SLOT_W-1:0] slot;
        logic [63:0]       due;
        logic [63:0]       pct;
        r = '0;
        r.arrival = now;
        win = (cfg_window == '0) ? 32'd1 : 32'(cfg_window);
        span = now - cfg_start;
        if (now < cfg_start || span < HOLDOFF_SECONDS) begin
            r.holdoff = 1'b1;
            return r;
        end
        cutoff = cfg_start;
        if (now >= win && now - win > cutoff) cutoff = now - win;
        if (live_stamps >= DEPTH) begin
            oldest_slot = oldest_slot + 1'b1;
            live_stamps = DEPTH - 1;
            r.overflow = 1'b1;
        end
        slot = oldest_slot + SLOT_W'(live_stamps);
        stamp_copy[slot] = now;
        live_stamps++;
        while (live_stamps > 0 && stamp_copy[oldest_slot] < cutoff) begin
            oldest_slot = oldest_slot + 1'b1;
            live_stamps--;
        end
        span = now - cutoff;
        due = (64'(cfg_expected) * 64'(span)) / 64'(win);
        if (due == 0) due = 1;
        pct = (64'd100 * 64'(live_stamps)) / due;
        if (pct > 64'(QUALITY_MAX)) pct = 64'(QUALITY_MAX);
        r.quality = pct[QUAL_W-1:0];
        return r;
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (idx)
            REG_WINDOW:   cfg_window   = value[WIN_W-1:0];
            REG_EXPECTED: cfg_expected = value[EXP_W-1:0];
            REG_START:    cfg_start    = value[TIME_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_reg(input logic [1:0] idx, input logic [31:0] want);
        logic [31:0] got;
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        got = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== want)
            flag_mismatch($sformatf("register %0d read %h want %h", idx, got, want));
    endtask

    task automatic send_word(input logic [TIME_W-1:0] arrival);
        int gap;
        @(negedge aclk);
        gap = steady ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= arrival;
        do @(posedge aclk); while (!s_tready);
        pending_scores.push_back(score_arrival(arrival));
    endtask

    // drop valid and let every pending result drain
    task automatic wait_idle();
        int n;
        @(negedge aclk);
        s_tvalid <= 1'b0;
        for (n = 0; n < 5000 && pending_scores.size() > 0; n++) @(negedge aclk);
        if (pending_scores.size() > 0) begin
            flag_mismatch($sformatf("%0d results never arrived", pending_scores.size()));
            pending_scores.delete();
        end
        repeat (4) @(negedge aclk);
    endtask

    task automatic test_register_access();
        check_reg(REG_WINDOW, 32'(WINDOW_RESET));
        check_reg(REG_EXPECTED, 32'(EXPECTED_RESET));
        check_reg(REG_START, 32'(START_RESET));
        write_reg(REG_WINDOW, 32'hFFFF_FFFF);
        check_reg(REG_WINDOW, 32'h0001_FFFF);
        write_reg(REG_EXPECTED, 32'hFFFF_FFFF);
        check_reg(REG_EXPECTED, 32'h0000_FFFF);
        write_reg(REG_START, 32'hFFFF_FFFF);
        check_reg(REG_START, 32'hFFFF_FFFF);
        write_reg(REG_SPARE, $urandom());
        check_reg(REG_WINDOW, 32'h0001_FFFF);
        check_reg(REG_EXPECTED, 32'h0000_FFFF);
        check_reg(REG_START, 32'hFFFF_FFFF);
        write_reg(REG_WINDOW, 32'(WINDOW_RESET));
        write_reg(REG_EXPECTED, 32'(EXPECTED_RESET));
        write_reg(REG_START, 32'(START_RESET));
    endtask

    task automatic test_holdoff();
        send_word(32'd0);
        send_word(32'd29);
        send_word(32'd30);
        send_word(32'd30);
        send_word(32'd1800);
        send_word(32'd3600);
        send_word(32'd7300);
        wait_idle();
        write_reg(REG_START, 32'd10000);
        send_word(32'd9000);
        send_word(32'd10029);
        send_word(32'd10030);
        wait_idle();
    endtask

    task automatic test_window_corners();
        write_reg(REG_WINDOW, 32'd0);
        write_reg(REG_EXPECTED, 32'd0);
        send_word(32'd10040);
        send_word(32'd10040);
        send_word(32'd10041);
        wait_idle();
        write_reg(REG_WINDOW, 32'd1);
        write_reg(REG_EXPECTED, 32'd65535);
        send_word(32'd10042);
        send_word(32'd10043);
        wait_idle();
        // a newer stamp ahead of an older one stops the prune walk
        write_reg(REG_WINDOW, 32'd100);
        write_reg(REG_EXPECTED, 32'd10);
        send_word(32'd10200);
        send_word(32'd10100);
        send_word(32'd10150);
        send_word(32'd10400);
        wait_idle();
        wall_clock = 10500;
    endtask

    task automatic test_random_traffic();
        int unsigned win;
        int unsigned per_window;
        int unsigned gap_max;
        int unsigned items;
        int unsigned pick;
        int unsigned back;
        int unsigned start;
        logic [TIME_W-1:0] arrival;
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: begin
                    win = 86400; per_window = 300; gap_max = 3; items = 320;
                end
                1: begin
                    win = 0; per_window = $urandom_range(1, 50); gap_max = 2; items = 96;
                end
                2: begin
                    win = 1; per_window = 65535; gap_max = 2; items = 96;
                end
                3: begin
                    win = $urandom_range(2, 600); per_window = $urandom_range(0, 2000);
                    gap_max = win / 4 + 1; items = 96;
                end
                4: begin
                    win = 131071; per_window = 0; gap_max = 5000; items = 96;
                end
                default: begin
                    win = $urandom_range(600, 86400); per_window = $urandom_range(1, 65535);
                    gap_max = win / 8; items = 96;
                end
            endcase
            wait_idle();
            write_reg(REG_WINDOW, win);
            write_reg(REG_EXPECTED, per_window);
            if ($urandom_range(0, 1))
                start = wall_clock + $urandom_range(0, 40);
            else
                start = wall_clock - $urandom_range(0, (wall_clock < win) ? wall_clock : win);
            write_reg(REG_START, start);
            steady = (p == 2);
            if (p == 3) long_hold = 300;
            for (int i = 0; i < items; i++) begin
                pick = $urandom_range(0, 99);
                if (pick < 5) begin
                    back = $urandom_range(1, 2 * win + 50);
                    arrival = (wall_clock > back) ? wall_clock - back : 32'd0;
                end else if (pick < 9) begin
                    if (pick == 8 && cfg_start > 0)
                        arrival = cfg_start - 1;
                    else
                        arrival = cfg_start + $urandom_range(0, 29);
                end else begin
                    if (pick == 99)
                        wall_clock += $urandom_range(0, 2 * win + 50);
                    else
                        wall_clock += $urandom_range(0, gap_max);
                    arrival = wall_clock;
                end
                send_word(arrival);
            end
            steady = 1'b0;
        end
        wait_idle();
    endtask

    task automatic test_time_extremes();
        write_reg(REG_START, 32'hFFFF_FFFF);
        send_word(32'hFFFF_FFFF);
        send_word(32'h0000_0000);
        wait_idle();
        write_reg(REG_WINDOW, 32'h0001_FFFF);
        write_reg(REG_EXPECTED, 32'd65535);
        write_reg(REG_START, 32'hFFFF_FF00);
        send_word(32'hFFFF_FF1D);
        send_word(32'hFFFF_FF1E);
        send_word(32'hFFFF_FFFF);
        wait_idle();
    endtask

    // result checker
    always @(posedge aclk) begin : check_results
        score_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_scores.size() == 0) begin
                flag_mismatch($sformatf("unexpected result word %h/%b", m_tdata, m_tuser));
            end else begin
                want = pending_scores.pop_front();
                if (m_tdata[QUAL_W-1:0] !== want.quality)
                    flag_mismatch($sformatf("t=%0d quality_percent %0d want %0d",
                                            want.arrival, m_tdata[QUAL_W-1:0], want.quality));
                if (m_tuser[0] !== want.holdoff)
                    flag_mismatch($sformatf("t=%0d in_holdoff %b want %b",
                                            want.arrival, m_tuser[0], want.holdoff));
                if (m_tuser[1] !== want.overflow)
                    flag_mismatch($sformatf("t=%0d ring_overflow %b want %b",
                                            want.arrival, m_tuser[1], want.overflow));
            end
        end
    end

    // result sink with random stalls and the occasional long hold
    initial begin : result_sink
        int stall;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (long_hold > 0) begin
                m_tready <= 1'b0;
                repeat (long_hold) @(negedge aclk);
                long_hold = 0;
            end
            stall = steady ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    initial begin
        #30_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        aresetn  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        mismatches   = 0;
        wall_clock   = 0;
        long_hold    = 0;
        steady       = 1'b0;
        cfg_window   = WINDOW_RESET;
        cfg_expected = EXPECTED_RESET;
        cfg_start    = START_RESET;
        oldest_slot  = '0;
        live_stamps  = 0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_register_access();
        test_holdoff();
        test_window_corners();
        test_random_traffic();
        test_time_extremes();

        wait_idle();
        repeat (400) @(negedge aclk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/swrq_pkg.sv
rtl/core/swrq_stamp_ram.sv
rtl/core/swrq_div.sv
rtl/core/sliding_window_reception_quality.sv
sim/testbench.sv
